[design/esc_pkg.sv]
package esc_pkg;

   localparam int CMD_W     = 2;
   localparam int RAW_W     = 20;
   localparam int VAL_W     = 32;
   localparam int WIDE_W    = 64;
   localparam int STEP_W    = 5;
   localparam int NREG      = 4;
   localparam int DST_W     = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 64;
   localparam int CNT_W     = 6;

   localparam int TEMP_W  = 48;
   localparam int PRESS_W = 64;
   localparam int MIXED_W = 56;
   localparam int HUM_W   = 24;

   localparam logic [VAL_W-1:0] HUM_CLAMP = 32'd419430400;

   typedef enum logic [CMD_W-1:0] {
      CMD_TEMP  = 2'd0,
      CMD_HUM   = 2'd1,
      CMD_PRESS = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEMP    = 3'd0,
      CSR_PRESS_A = 3'd1,
      CSR_PRESS_B = 3'd2,
      CSR_MIXED   = 3'd3,
      CSR_HUM     = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      OP_ALU,
      OP_MUL,
      OP_DIV,
      OP_FIN
   } op_type;

   typedef struct packed {
      logic              start;
      logic [WIDE_W-1:0] a;
      logic [WIDE_W-1:0] b;
   } unit_req_type;

   typedef struct packed {
      logic              done;
      logic [WIDE_W-1:0] y;
   } unit_rsp_type;

   typedef struct packed {
      logic [CMD_W-1:0] kind;
      logic [VAL_W-1:0] value;
      logic             fault;
   } result_type;

   function automatic logic [WIDE_W-1:0] sx32(logic [WIDE_W-1:0] x);
      return {{32{x[31]}}, x[31:0]};
   endfunction

   function automatic logic [WIDE_W-1:0] sra64(logic [WIDE_W-1:0] x, int unsigned n);
      return $unsigned($signed(x) >>> n);
   endfunction

endpackage

[design/esc_mul.sv]
module esc_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  esc_pkg::unit_req_type req,
   output esc_pkg::unit_rsp_type rsp
);
   import esc_pkg::*;

   logic              busy_ff, busy_in;
   logic [WIDE_W-1:0] a_ff, a_in;
   logic [WIDE_W-1:0] b_ff, b_in;
   logic [WIDE_W-1:0] acc_ff, acc_in;

   always_comb begin
      busy_in = busy_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (req.start) begin
         busy_in = 1'b1;
         a_in    = req.a;
         b_in    = req.b;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = {a_ff[WIDE_W-2:0], 1'b0};
            b_in = {1'b0, b_ff[WIDE_W-1:1]};
         end
      end
   end

   assign rsp.done = busy_ff && (b_ff == '0);
   assign rsp.y    = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

endmodule

[design/esc_div.sv]
module esc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  esc_pkg::unit_req_type req,
   output esc_pkg::unit_rsp_type rsp
);
   import esc_pkg::*;

   logic              busy_ff, busy_in;
   logic              fin_ff, fin_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WIDE_W-1:0] rem_ff, rem_in;
   logic [WIDE_W-1:0] quo_ff, quo_in;
   logic [WIDE_W-1:0] den_ff, den_in;
   logic [WIDE_W:0]   trial;
   logic [WIDE_W:0]   diff;

   assign trial = {rem_ff, quo_ff[WIDE_W-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         neg_in  = req.a[WIDE_W-1] ^ req.b[WIDE_W-1];
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.a[WIDE_W-1] ? (~req.a + 1'b1) : req.a;
         den_in  = req.b[WIDE_W-1] ? (~req.b + 1'b1) : req.b;
      end else if (busy_ff) begin
         if (!diff[WIDE_W]) begin
            rem_in = diff[WIDE_W-1:0];
            quo_in = {quo_ff[WIDE_W-2:0], 1'b1};
         end else begin
            rem_in = trial[WIDE_W-1:0];
            quo_in = {quo_ff[WIDE_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
   end

   assign rsp.done = fin_ff;
   assign rsp.y    = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

endmodule

[design/esc_seq.sv]
module esc_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                go,
   input  logic [esc_pkg::CMD_W-1:0]           go_command,
   input  logic [esc_pkg::RAW_W-1:0]           go_raw,
   input  logic [esc_pkg::TEMP_W-1:0]          temp_coeffs,
   input  logic [esc_pkg::PRESS_W-1:0]         press_coeffs_a,
   input  logic [esc_pkg::PRESS_W-1:0]         press_coeffs_b,
   input  logic [esc_pkg::MIXED_W-1:0]         mixed_coeffs,
   input  logic [esc_pkg::HUM_W-1:0]           hum_coeffs_mid,
   output logic                                idle,
   output logic                                res_valid,
   input  logic                                res_ready,
   output esc_pkg::result_type                 res
);
   import esc_pkg::*;

   state_type                   state_ff, state_in;
   cmd_type                     cmd_ff, cmd_in;
   logic [RAW_W-1:0]            raw_ff, raw_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic [NREG-1:0][WIDE_W-1:0] x_ff, x_in;
   logic [VAL_W-1:0]            ft_ff, ft_in;
   result_type                  res_ff, res_in;

   op_type            op;
   logic [DST_W-1:0]  dst;
   logic [WIDE_W-1:0] alu_val, ma, mb;
   logic [WIDE_W-1:0] fin_wide;
   logic [VAL_W-1:0]  fin_val;
   logic              fin_fault, set_ft, w32;

   unit_req_type mul_req, div_req;
   unit_rsp_type mul_rsp, div_rsp;

   logic [WIDE_W-1:0] x0, x1, x2, x3, adc20, adc16;
   logic [WIDE_W-1:0] t1, t2, t3;
   logic [WIDE_W-1:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic [WIDE_W-1:0] h1, h2, h3, h4, h5, h6;
   logic [WIDE_W-1:0] ft64;

   esc_mul u_mul (.clock(clock), .reset(reset), .req(mul_req), .rsp(mul_rsp));
   esc_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   assign x0 = x_ff[0];
   assign x1 = x_ff[1];
   assign x2 = x_ff[2];
   assign x3 = x_ff[3];

   assign adc20 = {{(WIDE_W-RAW_W){1'b0}}, raw_ff};
   assign adc16 = {48'd0, raw_ff[15:0]};
   assign ft64  = {{32{ft_ff[31]}}, ft_ff};
   assign w32   = (cmd_ff != CMD_PRESS);

   assign t1 = {48'd0, temp_coeffs[15:0]};
   assign t2 = {{48{temp_coeffs[31]}}, temp_coeffs[31:16]};
   assign t3 = {{48{temp_coeffs[47]}}, temp_coeffs[47:32]};
   assign p1 = {48'd0, press_coeffs_a[15:0]};
   assign p2 = {{48{press_coeffs_a[31]}}, press_coeffs_a[31:16]};
   assign p3 = {{48{press_coeffs_a[47]}}, press_coeffs_a[47:32]};
   assign p4 = {{48{press_coeffs_a[63]}}, press_coeffs_a[63:48]};
   assign p5 = {{48{press_coeffs_b[15]}}, press_coeffs_b[15:0]};
   assign p6 = {{48{press_coeffs_b[31]}}, press_coeffs_b[31:16]};
   assign p7 = {{48{press_coeffs_b[47]}}, press_coeffs_b[47:32]};
   assign p8 = {{48{press_coeffs_b[63]}}, press_coeffs_b[63:48]};
   assign p9 = {{48{mixed_coeffs[15]}}, mixed_coeffs[15:0]};
   assign h1 = {56'd0, mixed_coeffs[23:16]};
   assign h2 = {{48{mixed_coeffs[39]}}, mixed_coeffs[39:24]};
   assign h3 = {56'd0, mixed_coeffs[47:40]};
   assign h6 = {{56{mixed_coeffs[55]}}, mixed_coeffs[55:48]};
   assign h4 = {{52{hum_coeffs_mid[11]}}, hum_coeffs_mid[11:0]};
   assign h5 = {{52{hum_coeffs_mid[23]}}, hum_coeffs_mid[23:12]};

   // step decode
   always_comb begin
      op        = OP_FIN;
      dst       = '0;
      alu_val   = '0;
      ma        = '0;
      mb        = '0;
      fin_wide  = '0;
      fin_val   = '0;
      fin_fault = 1'b0;
      set_ft    = 1'b0;
      unique case (cmd_ff)
         CMD_TEMP: begin
            unique case (step_ff)
               5'd0: begin
                  op = OP_ALU; dst = 2'd0;
                  alu_val = sx32((adc20 >> 3) - (t1 << 1));
               end
               5'd1: begin op = OP_MUL; dst = 2'd0; ma = x0; mb = t2; end
               5'd2: begin
                  op = OP_ALU; dst = 2'd1;
                  alu_val = sx32((adc20 >> 4) - t1);
               end
               5'd3: begin op = OP_MUL; dst = 2'd1; ma = x1; mb = x1; end
               5'd4: begin op = OP_MUL; dst = 2'd1; ma = sra64(x1, 12); mb = t3; end
               5'd5: begin
                  op = OP_ALU; dst = 2'd2; set_ft = 1'b1;
                  alu_val = sx32(sra64(x0, 11) + sra64(x1, 14));
               end
               5'd6: begin op = OP_MUL; dst = 2'd0; ma = x2; mb = 64'd5; end
               default: begin
                  op = OP_FIN;
                  fin_wide = sra64(sx32(x0 + 64'd128), 8);
                  fin_val  = fin_wide[VAL_W-1:0];
               end
            endcase
         end
         CMD_HUM: begin
            unique case (step_ff)
               5'd0: begin op = OP_ALU; dst = 2'd0; alu_val = sx32(ft64 - 64'd76800); end
               5'd1: begin op = OP_MUL; dst = 2'd1; ma = h5; mb = x0; end
               5'd2: begin
                  op = OP_ALU; dst = 2'd2;
                  alu_val = sx32((adc16 << 14) - (h4 << 20));
               end
               5'd3: begin
                  op = OP_ALU; dst = 2'd2;
                  alu_val = sx32(x2 - x1 + 64'd16384);
               end
               5'd4: begin op = OP_MUL; dst = 2'd1; ma = x0; mb = h6; end
               5'd5: begin op = OP_MUL; dst = 2'd3; ma = x0; mb = h3; end
               5'd6: begin
                  op = OP_ALU; dst = 2'd3;
                  alu_val = sx32(sra64(x3, 11) + 64'd32768);
               end
               5'd7: begin op = OP_MUL; dst = 2'd1; ma = sra64(x1, 10); mb = x3; end
               5'd8: begin
                  op = OP_ALU; dst = 2'd1;
                  alu_val = sx32(sra64(x1, 10) + 64'd2097152);
               end
               5'd9: begin op = OP_MUL; dst = 2'd1; ma = x1; mb = h2; end
               5'd10: begin op = OP_ALU; dst = 2'd1; alu_val = sx32(x1 + 64'd8192); end
               5'd11: begin
                  op = OP_MUL; dst = 2'd2; ma = sra64(x2, 15); mb = sra64(x1, 14);
               end
               5'd12: begin
                  op = OP_MUL; dst = 2'd1; ma = sra64(x2, 15); mb = sra64(x2, 15);
               end
               5'd13: begin op = OP_MUL; dst = 2'd1; ma = sra64(x1, 7); mb = h1; end
               5'd14: begin
                  op = OP_ALU; dst = 2'd2;
                  alu_val = sx32(x2 - sra64(x1, 4));
               end
               default: begin
                  op = OP_FIN;
                  if (x2[31]) begin
                     fin_val = '0;
                  end else if (x2[31:0] > HUM_CLAMP) begin
                     fin_val = HUM_CLAMP >> 12;
                  end else begin
                     fin_val = x2[31:0] >> 12;
                  end
               end
            endcase
         end
         CMD_PRESS: begin
            unique case (step_ff)
               5'd0: begin op = OP_ALU; dst = 2'd0; alu_val = ft64 - 64'd128000; end
               5'd1: begin op = OP_MUL; dst = 2'd1; ma = x0; mb = x0; end
               5'd2: begin op = OP_MUL; dst = 2'd2; ma = x1; mb = p6; end
               5'd3: begin op = OP_MUL; dst = 2'd3; ma = x0; mb = p5; end
               5'd4: begin op = OP_ALU; dst = 2'd2; alu_val = x2 + (x3 << 17); end
               5'd5: begin op = OP_ALU; dst = 2'd2; alu_val = x2 + (p4 << 35); end
               5'd6: begin op = OP_MUL; dst = 2'd3; ma = x1; mb = p3; end
               5'd7: begin op = OP_MUL; dst = 2'd1; ma = x0; mb = p2; end
               5'd8: begin
                  op = OP_ALU; dst = 2'd0;
                  alu_val = sra64(x3, 8) + (x1 << 12);
               end
               5'd9: begin op = OP_ALU; dst = 2'd0; alu_val = x0 + (64'd1 << 47); end
               5'd10: begin op = OP_MUL; dst = 2'd0; ma = x0; mb = p1; end
               5'd11: begin op = OP_ALU; dst = 2'd0; alu_val = sra64(x0, 33); end
               5'd12: begin
                  if (x0 == '0) begin
                     op = OP_FIN; fin_fault = 1'b1;
                  end else begin
                     op = OP_ALU; dst = 2'd1; alu_val = 64'd1048576 - adc20;
                  end
               end
               5'd13: begin op = OP_ALU; dst = 2'd1; alu_val = (x1 << 31) - x2; end
               5'd14: begin op = OP_MUL; dst = 2'd1; ma = x1; mb = 64'd3125; end
               5'd15: begin op = OP_DIV; dst = 2'd1; ma = x1; mb = x0; end
               5'd16: begin op = OP_MUL; dst = 2'd2; ma = p9; mb = sra64(x1, 13); end
               5'd17: begin op = OP_MUL; dst = 2'd2; ma = x2; mb = sra64(x1, 13); end
               5'd18: begin op = OP_MUL; dst = 2'd3; ma = p8; mb = x1; end
               5'd19: begin
                  op = OP_ALU; dst = 2'd0;
                  alu_val = x1 + sra64(x2, 25) + sra64(x3, 19);
               end
               5'd20: begin
                  op = OP_ALU; dst = 2'd0;
                  alu_val = sra64(x0, 8) + (p7 << 4);
               end
               default: begin
                  op = OP_FIN;
                  if (!x0[63] && (x0[62:31] != '0)) begin
                     fin_val = 32'h7FFF_FFFF;
                  end else if (x0[63] && (x0[62:31] != '1)) begin
                     fin_val = 32'h8000_0000;
                  end else begin
                     fin_val = x0[31:0];
                  end
               end
            endcase
         end
         default: begin
            op = OP_FIN;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (go) begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            unique case (op)
               OP_ALU: state_in = ST_EXEC;
               OP_MUL: state_in = ST_MUL;
               OP_DIV: state_in = ST_DIV;
               OP_FIN: state_in = ST_DONE;
               default: state_in = ST_EXEC;
            endcase
         end
         ST_MUL: if (mul_rsp.done) begin
            state_in = ST_EXEC;
         end
         ST_DIV: if (div_rsp.done) begin
            state_in = ST_EXEC;
         end
         ST_DONE: if (res_ready) begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      cmd_in    = cmd_ff;
      raw_in    = raw_ff;
      step_in   = step_ff;
      x_in      = x_ff;
      ft_in     = ft_ff;
      res_in    = res_ff;
      mul_req   = '0;
      div_req   = '0;
      idle      = (state_ff == ST_IDLE);
      res_valid = (state_ff == ST_DONE);
      res       = res_ff;
      unique case (state_ff)
         ST_IDLE: if (go) begin
            cmd_in  = cmd_type'(go_command);
            raw_in  = go_raw;
            step_in = '0;
         end
         ST_EXEC: begin
            unique case (op)
               OP_ALU: begin
                  x_in[dst] = alu_val;
                  if (set_ft) begin
                     ft_in = alu_val[VAL_W-1:0];
                  end
                  step_in = step_ff + 1'b1;
               end
               OP_MUL: begin
                  mul_req.start = 1'b1;
                  mul_req.a     = ma;
                  mul_req.b     = w32 ? {32'd0, mb[31:0]} : mb;
               end
               OP_DIV: begin
                  div_req.start = 1'b1;
                  div_req.a     = ma;
                  div_req.b     = mb;
               end
               OP_FIN: begin
                  res_in.kind  = cmd_ff;
                  res_in.value = fin_val;
                  res_in.fault = fin_fault;
               end
               default: ;
            endcase
         end
         ST_MUL: if (mul_rsp.done) begin
            x_in[dst] = w32 ? sx32(mul_rsp.y) : mul_rsp.y;
            step_in   = step_ff + 1'b1;
         end
         ST_DIV: if (div_rsp.done) begin
            x_in[dst] = div_rsp.y;
            step_in   = step_ff + 1'b1;
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ft_ff    <= '0;
      end else begin
         state_ff <= state_in;
         ft_ff    <= ft_in;
      end
      cmd_ff  <= cmd_in;
      raw_ff  <= raw_in;
      step_ff <= step_in;
      x_ff    <= x_in;
      res_ff  <= res_in;
   end

endmodule

[design/env_sensor_compensation.sv]
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | req_command, req_raw_sample
// rsp     | out       | rsp_valid / rsp_ready | rsp_kind, rsp_value, rsp_divide_fault
// csr     | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// one request at a time; products come from a bit-serial shift-add multiplier
// and the pressure quotient from a one-bit-per-cycle restoring divider
// a multiply ends early when its multiplier runs out
// synchronous reset clears control, fine temperature and calibration registers
// a request is taken while an earlier result waits in the rsp register
module env_sensor_compensation (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [esc_pkg::CMD_W-1:0]           req_command,
   input  logic [esc_pkg::RAW_W-1:0]           req_raw_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [esc_pkg::CMD_W-1:0]           rsp_kind,
   output logic signed [esc_pkg::VAL_W-1:0]    rsp_value,
   output logic                                rsp_divide_fault,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [esc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [esc_pkg::CSR_W-1:0]           csr_wdata
);
   import esc_pkg::*;

   logic [TEMP_W-1:0]  temp_ff, temp_in;
   logic [PRESS_W-1:0] pa_ff, pa_in;
   logic [PRESS_W-1:0] pb_ff, pb_in;
   logic [MIXED_W-1:0] mx_ff, mx_in;
   logic [HUM_W-1:0]   hm_ff, hm_in;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   logic       seq_idle, seq_res_valid, seq_res_ready;
   result_type seq_res;

   esc_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .go             (req_valid && req_ready),
      .go_command     (req_command),
      .go_raw         (req_raw_sample),
      .temp_coeffs    (temp_ff),
      .press_coeffs_a (pa_ff),
      .press_coeffs_b (pb_ff),
      .mixed_coeffs   (mx_ff),
      .hum_coeffs_mid (hm_ff),
      .idle           (seq_idle),
      .res_valid      (seq_res_valid),
      .res_ready      (seq_res_ready),
      .res            (seq_res)
   );

   assign req_ready     = seq_idle;
   assign csr_ready     = 1'b1;
   assign seq_res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      temp_in = temp_ff;
      pa_in   = pa_ff;
      pb_in   = pb_ff;
      mx_in   = mx_ff;
      hm_in   = hm_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TEMP:    temp_in = csr_wdata[TEMP_W-1:0];
            CSR_PRESS_A: pa_in   = csr_wdata;
            CSR_PRESS_B: pb_in   = csr_wdata;
            CSR_MIXED:   mx_in   = csr_wdata[MIXED_W-1:0];
            CSR_HUM:     hm_in   = csr_wdata[HUM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (seq_res_valid && seq_res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = seq_res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff      <= '0;
         pa_ff        <= '0;
         pb_ff        <= '0;
         mx_ff        <= '0;
         hm_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         temp_ff      <= temp_in;
         pa_ff        <= pa_in;
         pb_ff        <= pb_in;
         mx_ff        <= mx_in;
         hm_ff        <= hm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_value        = $signed(rsp_ff.value);
   assign rsp_divide_fault = rsp_ff.fault;

`ifndef NO_ASSERTIONS
   a_fault_only_pressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_fault |-> rsp_kind == CMD_PRESS && rsp_value == 0)
      else $error("divide fault on a non-pressure or nonzero result");

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while engine still busy");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == CMD_HUM |-> rsp_value >= 0 && rsp_value <= 102400)
      else $error("humidity result outside clamp window");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import esc_pkg::*;

   typedef struct {
      logic [CMD_W-1:0] kind;
      logic [31:0]      value;
      logic             fault;
   } reading_type;

   class reading_board;
      reading_type pending[$];
      int errors;
      int checked;

      function void note(reading_type r);
         pending.push_back(r);
      endfunction

      task check(logic [CMD_W-1:0] kind, logic [31:0] value, logic fault);
         reading_type e;
         checked++;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result kind %0d value %h", kind, value));
         end else begin
            e = pending.pop_front();
            if (kind !== e.kind || value !== e.value || fault !== e.fault)
               report($sformatf("got kind %0d value %h fault %b, want %0d %h %b",
                  kind, value, fault, e.kind, e.value, e.fault));
         end
      endtask

      task report(string msg);
         errors++;
         $display("ERROR %0t: %s", $time, msg);
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [CMD_W-1:0] req_command = '0;
   logic [RAW_W-1:0] req_raw_sample = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [CMD_W-1:0] rsp_kind;
   logic signed [VAL_W-1:0] rsp_value;
   logic rsp_divide_fault;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   env_sensor_compensation uut (.*);

   always #4 clock = ~clock;

   reading_board board = new();
   logic [47:0] k_temp;
   logic [63:0] k_pa, k_pb;
   logic [55:0] k_mixed;
   logic [23:0] k_hum;
   logic [31:0] fine;
   int hold_off = 0;
   int sent = 0;
   bit stim_done = 0;

   function automatic logic [31:0] asr32(logic [31:0] x, int n);
      return $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [63:0] asr64(logic [63:0] x, int n);
      return $unsigned($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sext16(logic [15:0] x);
      return {{16{x[15]}}, x};
   endfunction

   function automatic logic [31:0] temp_value(logic [19:0] adc);
      logic [31:0] t1, t2, t3, d1, v1, d2, v2;
      t1 = {16'd0, k_temp[15:0]};
      t2 = sext16(k_temp[31:16]);
      t3 = sext16(k_temp[47:32]);
      d1 = {12'd0, adc} / 8 - (t1 << 1);
      v1 = asr32(d1 * t2, 11);
      d2 = {12'd0, adc} / 16 - t1;
      v2 = asr32(asr32(d2 * d2, 12) * t3, 14);
      fine = v1 + v2;
      return asr32(fine * 5 + 128, 8);
   endfunction

   function automatic logic [31:0] hum_value(logic [15:0] adc);
      logic [31:0] h1, h2, h3, h4, h5, h6, v, a, b, c, d, e, t;
      h1 = {24'd0, k_mixed[23:16]};
      h2 = sext16(k_mixed[39:24]);
      h3 = {24'd0, k_mixed[47:40]};
      h6 = {{24{k_mixed[55]}}, k_mixed[55:48]};
      h4 = {{20{k_hum[11]}}, k_hum[11:0]};
      h5 = {{20{k_hum[23]}}, k_hum[23:12]};
      v = fine - 76800;
      a = asr32(({16'd0, adc} << 14) - (h4 << 20) - h5 * v + 16384, 15);
      b = asr32(v * h6, 10);
      c = asr32(v * h3, 11) + 32768;
      d = asr32(b * c, 10) + 2097152;
      e = asr32(d * h2 + 8192, 14);
      v = a * e;
      t = asr32(v, 15);
      v = v - asr32(asr32(t * t, 7) * h1, 4);
      if (v[31]) v = 0;
      else if (v > HUM_CLAMP) v = HUM_CLAMP;
      return v >> 12;
   endfunction

   function automatic logic [63:0] sx16w(logic [15:0] x);
      return {{48{x[15]}}, x};
   endfunction

   function automatic void press_value(logic [19:0] adc, output logic [31:0] val,
                                       output logic flt);
      logic signed [63:0] v1, v2, p, t, den;
      logic [63:0] p1;
      p1 = {48'd0, k_pa[15:0]};
      v1 = $signed({{32{fine[31]}}, fine}) - 128000;
      v2 = v1 * v1 * $signed(sx16w(k_pb[31:16]));
      v2 = v2 + ((v1 * $signed(sx16w(k_pb[15:0]))) <<< 17);
      v2 = v2 + ($signed(sx16w(k_pa[63:48])) <<< 35);
      v1 = (v1 * v1 * $signed(sx16w(k_pa[47:32])) >>> 8)
         + ((v1 * $signed(sx16w(k_pa[31:16]))) <<< 12);
      den = $signed((64'h8000_0000_0000 + $unsigned(v1)) * p1) >>> 33;
      flt = 0;
      if (den == 0) begin
         val = 0;
         flt = 1;
         return;
      end
      p = 64'd1048576 - {44'd0, adc};
      p = ((p <<< 31) - v2) * 64'sd3125;
      if (den == -1) p = -p;
      else p = p / den;
      t = p >>> 13;
      v1 = ($signed(sx16w(k_mixed[15:0])) * t * t) >>> 25;
      v2 = ($signed(sx16w(k_pb[63:48])) * p) >>> 19;
      p = ((p + v1 + v2) >>> 8) + ($signed(sx16w(k_pb[47:32])) <<< 4);
      if (p > 64'sd2147483647) val = 32'h7fffffff;
      else if (p < -64'sd2147483648) val = 32'h80000000;
      else val = p[31:0];
   endfunction

   function automatic reading_type predict(logic [CMD_W-1:0] cmd, logic [19:0] raw);
      reading_type r;
      r.kind = cmd;
      r.value = 0;
      r.fault = 0;
      case (cmd)
         CMD_TEMP: r.value = temp_value(raw);
         CMD_HUM: r.value = hum_value(raw[15:0]);
         CMD_PRESS: press_value(raw, r.value, r.fault);
         default: ;
      endcase
      return r;
   endfunction

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      repeat (n) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [63:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TEMP: k_temp = data[47:0];
         CSR_PRESS_A: k_pa = data;
         CSR_PRESS_B: k_pb = data;
         CSR_MIXED: k_mixed = data[55:0];
         CSR_HUM: k_hum = data[23:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   task automatic send(logic [CMD_W-1:0] cmd, logic [19:0] raw, bit gaps);
      req_valid <= 1;
      req_command <= cmd;
      req_raw_sample <= raw;
      do @(posedge clock); while (!req_ready);
      board.note(predict(cmd, raw));
      sent++;
      @(negedge clock);
      req_valid <= 0;
      @(negedge clock);
      if (gaps) idle_gap();
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(negedge clock);
      repeat (1000) @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic random_regs(int mode);
      logic [63:0] pa;
      pa = rand64();
      if (mode == 1) pa[15:0] = 0;
      write_reg(CSR_TEMP, mode == 2 ? 64'hffff_ffff_ffff : rand64());
      write_reg(CSR_PRESS_A, mode == 2 ? 64'hffff_ffff_ffff_ffff : pa);
      write_reg(CSR_PRESS_B, mode == 2 ? 64'hffff_ffff_ffff_ffff : rand64());
      write_reg(CSR_MIXED, mode == 2 ? 64'hff_ffff_ffff_ffff : rand64());
      write_reg(CSR_HUM, mode == 2 ? 64'hff_ffff : rand64());
   endtask

   task automatic typical_regs();
      write_reg(CSR_TEMP, {16'd0, 16'd50, 16'd26435, 16'd27504});
      write_reg(CSR_PRESS_A, {16'd2855, 16'hd0a8, 16'hd5d0, 16'd36477});
      write_reg(CSR_PRESS_B, {16'hffc0, 16'hfff9, 16'd140, 16'd140});
      write_reg(CSR_MIXED, {8'd0, 8'd30, 8'd0, 16'd363, 8'd75, 16'd4000});
      write_reg(CSR_HUM, {40'd0, 12'd50, 12'd300});
   endtask

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         board.check(rsp_kind, rsp_value, rsp_divide_fault);

   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
      end
   end

   initial begin
      k_temp = 0; k_pa = 0; k_pb = 0; k_mixed = 0; k_hum = 0; fine = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // fine temperature is zero after reset, zero registers give a divide fault
      send(CMD_HUM, 20'hfffff, 0);
      send(CMD_PRESS, 20'd0, 0);
      send(CMD_NONE, 20'habcde, 0);
      drain();

      typical_regs();
      send(CMD_TEMP, 20'd519888, 0);
      send(CMD_HUM, 20'd30000, 0);
      send(CMD_PRESS, 20'd415148, 0);
      send(CMD_TEMP, 20'd0, 0);
      send(CMD_PRESS, 20'hfffff, 0);
      send(CMD_HUM, 20'd0, 0);
      send(CMD_TEMP, 20'hfffff, 0);
      send(CMD_HUM, 20'hffff, 0);
      send(CMD_PRESS, 20'd0, 0);
      send(CMD_NONE, 20'd0, 0);
      drain();

      random_regs(2);
      send(CMD_TEMP, 20'hfffff, 0);
      send(CMD_HUM, 20'h5a5a5, 0);
      send(CMD_PRESS, 20'h12345, 0);
      drain();

      // long receiver stall while requests keep coming
      hold_off = 400;
      for (int i = 0; i < 6; i++) send(CMD_TEMP, RAW_W'($urandom_range(0, 20'hfffff)), 0);

      for (int ph = 0; ph < 7; ph++) begin
         drain();
         if (ph == 0) typical_regs();
         else random_regs(ph == 3 ? 1 : (ph == 5 ? 2 : 0));
         for (int i = 0; i < 100; i++) begin
            logic [CMD_W-1:0] c;
            c = ($urandom_range(0, 19) == 0) ? CMD_NONE : CMD_W'($urandom_range(0, 2));
            send(c, RAW_W'($urandom_range(0, 20'hfffff)), 1);
         end
      end
      // register write to an unused index must be ignored
      drain();
      write_reg(csr_index_type'(3'd7), rand64());
      send(CMD_PRESS, 20'd415148, 0);
      send(CMD_HUM, 20'd30000, 0);
      drain();
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      $display("sent %0d requests over several calibration sets, checked %0d results",
         sent, board.checked);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d left over", board.errors, board.pending.size());
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("Verification failed");
      $finish;
   end
endmodule
